/* hw/rtl/depth_pixel_back_projection_core_macros.svh */
// assertion helpers used by the fifo
`ifndef DEPTH_PIXEL_BACK_PROJECTION_CORE_MACROS_SVH
`define DEPTH_PIXEL_BACK_PROJECTION_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define DPBP_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dpbp: same-cycle check failed");
// next-cycle implication
`define DPBP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dpbp: next-cycle check failed");
`else
`define DPBP_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define DPBP_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* hw/rtl/dpbp_pkg.sv */
package dpbp_pkg;

  // pixel index handling
  localparam int IDX_BITS   = 12;
  localparam int COORD_BITS = 12;
  localparam int U_BITS     = (COORD_BITS < IDX_BITS) ? COORD_BITS : IDX_BITS;

  // queue between front and back
  localparam int QUEUE_DEPTH  = 4;
  localparam int PTR_W        = $clog2(QUEUE_DEPTH);
  localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int FRONT_STAGES = 2;

  // register port
  localparam int NUM_REGS = 8;
  localparam int ADDR_W   = $clog2(NUM_REGS) + 3;
  localparam int DATA_W   = 64;

  // register reset values
  localparam logic [31:0] DEPTH_SCALE_RESET = 32'd858993;
  localparam int          MAX_DEPTH_METRES  = 7;
  localparam logic [15:0] MAX_DEPTH_RESET   = 16'(MAX_DEPTH_METRES << 12);

  // datapath widths
  localparam int PROD_W = 48;
  localparam int Z_W    = 20;
  localparam int DU_W   = 17;
  localparam int ZF_W   = 44;
  localparam int CAM_W  = 34;
  localparam int ACC_W  = 52;
  localparam int OUT_W  = 24;

  localparam logic signed [OUT_W-1:0] OUT_MAX = 24'sh7fffff;
  localparam logic signed [OUT_W-1:0] OUT_MIN = 24'sh800000;

  typedef enum logic [2:0] {
    REG_INV_DEPTH_SCALE,
    REG_MAX_DEPTH,
    REG_PRINCIPAL_POINT,
    REG_INV_FOCAL,
    REG_ROT_ROW0,
    REG_ROT_ROW1,
    REG_ROT_ROW2,
    REG_TRANSLATION
  } reg_idx_t;

  typedef struct packed {
    logic [11:0] col;
    logic [11:0] row_idx;
    logic [15:0] depth_raw;
    logic [7:0]  blue_in;
    logic [7:0]  green_in;
    logic [7:0]  red_in;
  } pixel_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] world_x;
    logic signed [OUT_W-1:0] world_y;
    logic signed [OUT_W-1:0] world_z;
    logic [7:0]              blue_out;
    logic [7:0]              green_out;
    logic [7:0]              red_out;
  } point_t;

  typedef struct packed {
    logic [31:0] inv_depth_scale;
    logic [15:0] max_depth;
    logic [31:0] principal_point;
    logic [47:0] inv_focal;
    logic [47:0] rot_row0;
    logic [47:0] rot_row1;
    logic [47:0] rot_row2;
    logic [62:0] translation;
  } cfg_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  typedef struct packed {
    logic [Z_W-1:0]         z;
    logic signed [DU_W-1:0] du;
    logic signed [DU_W-1:0] dv;
    rgb_t                   rgb;
  } q_item_t;

endpackage

/* hw/rtl/dpbp_regs.sv */
module dpbp_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dpbp_pkg::ADDR_W-1:0]   paddr,
  input  logic [dpbp_pkg::DATA_W-1:0]   pwdata,
  output logic [dpbp_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output dpbp_pkg::cfg_t                cfg
);
  import dpbp_pkg::*;

  logic     wr;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inv_depth_scale <= DEPTH_SCALE_RESET;
      cfg.max_depth       <= MAX_DEPTH_RESET;
      cfg.principal_point <= '0;
      cfg.inv_focal       <= '0;
      cfg.rot_row0        <= '0;
      cfg.rot_row1        <= '0;
      cfg.rot_row2        <= '0;
      cfg.translation     <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_INV_DEPTH_SCALE: cfg.inv_depth_scale <= pwdata[31:0];
        REG_MAX_DEPTH:       cfg.max_depth       <= pwdata[15:0];
        REG_PRINCIPAL_POINT: cfg.principal_point <= pwdata[31:0];
        REG_INV_FOCAL:       cfg.inv_focal       <= pwdata[47:0];
        REG_ROT_ROW0:        cfg.rot_row0        <= pwdata[47:0];
        REG_ROT_ROW1:        cfg.rot_row1        <= pwdata[47:0];
        REG_ROT_ROW2:        cfg.rot_row2        <= pwdata[47:0];
        REG_TRANSLATION:     cfg.translation     <= pwdata[62:0];
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_INV_DEPTH_SCALE: prdata = DATA_W'(cfg.inv_depth_scale);
      REG_MAX_DEPTH:       prdata = DATA_W'(cfg.max_depth);
      REG_PRINCIPAL_POINT: prdata = DATA_W'(cfg.principal_point);
      REG_INV_FOCAL:       prdata = DATA_W'(cfg.inv_focal);
      REG_ROT_ROW0:        prdata = DATA_W'(cfg.rot_row0);
      REG_ROT_ROW1:        prdata = DATA_W'(cfg.rot_row1);
      REG_ROT_ROW2:        prdata = DATA_W'(cfg.rot_row2);
      REG_TRANSLATION:     prdata = DATA_W'(cfg.translation);
    endcase
  end

endmodule

/* hw/rtl/dpbp_front.sv */
module dpbp_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  dpbp_pkg::pixel_t             pixel,
  input  dpbp_pkg::cfg_t               cfg,
  input  logic [dpbp_pkg::CNT_W-1:0]   q_count,
  output logic                         push,
  output dpbp_pkg::q_item_t            push_item
);
  import dpbp_pkg::*;

  localparam int PEND_W = CNT_W + 1;

  logic               accept;
  logic [PEND_W-1:0]  pending;
  logic               s1_valid;
  pixel_t             s1_pixel;
  logic               s2_valid;
  pixel_t             s2_pixel;
  logic [PROD_W-1:0]  s2_prod;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  limit;
  logic               keep;
  logic [35:0]        z_sum;
  logic [IDX_BITS-1:0] u;
  logic [IDX_BITS-1:0] v;

  // hold off when the queue could not take every item in flight
  assign pending = PEND_W'(q_count) + PEND_W'(s1_valid) + PEND_W'(s2_valid);
  assign busy    = pending >= PEND_W'(QUEUE_DEPTH);
  assign accept  = start & ~busy;

  // depth scaling product
  assign prod = PROD_W'(s1_pixel.depth_raw) * PROD_W'(cfg.inv_depth_scale);

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel <= pixel;
    end
    if (s1_valid) begin
      s2_pixel <= s1_pixel;
      s2_prod  <= prod;
    end
  end

  // classify: no measurement or beyond the far limit is dropped
  assign limit = {12'd0, cfg.max_depth, 20'd0};
  assign keep  = (s2_prod != '0) && (s2_prod <= limit);
  assign push  = s2_valid & keep;

  // camera z and offsets from the principal point
  assign z_sum = s2_prod[35:0] + 36'h8000;
  assign u     = IDX_BITS'(s2_pixel.col[U_BITS-1:0]);
  assign v     = IDX_BITS'(s2_pixel.row_idx[U_BITS-1:0]);

  always_comb begin
    push_item.z         = z_sum[35:16];
    push_item.du        = $signed({1'b0, u, 4'b0000})
                          - $signed({1'b0, cfg.principal_point[15:0]});
    push_item.dv        = $signed({1'b0, v, 4'b0000})
                          - $signed({1'b0, cfg.principal_point[31:16]});
    push_item.rgb.blue  = s2_pixel.blue_in;
    push_item.rgb.green = s2_pixel.green_in;
    push_item.rgb.red   = s2_pixel.red_in;
  end

endmodule

/* hw/rtl/dpbp_fifo.sv */
`include "depth_pixel_back_projection_core_macros.svh"

module dpbp_fifo (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  dpbp_pkg::q_item_t            push_item,
  output logic                         head_valid,
  output dpbp_pkg::q_item_t            head_item,
  output logic [dpbp_pkg::CNT_W-1:0]   count
);
  import dpbp_pkg::*;

  q_item_t          entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             pop;
  logic             full;

  // the back end never stalls, so the head leaves as soon as it is there
  assign head_valid = count != '0;
  assign pop        = head_valid;
  assign head_item  = entries[rd_ptr];
  assign full       = count == CNT_W'(QUEUE_DEPTH);

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  `DPBP_ASSERT_IMPLY(a_push_not_full, clk, rst, push, !full)
  `DPBP_ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == $past(count) + CNT_W'(1))
  `DPBP_ASSERT_NEXT(a_count_down, clk, rst, pop && !push, count == $past(count) - CNT_W'(1))

endmodule

/* hw/rtl/dpbp_back.sv */
module dpbp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  dpbp_pkg::q_item_t    head_item,
  input  dpbp_pkg::cfg_t       cfg,
  output logic                 done,
  output dpbp_pkg::point_t     point
);
  import dpbp_pkg::*;

  localparam int PP_W    = 40;
  localparam int VX_W    = 62;
  localparam int HALF_W  = ZF_W / 2;
  localparam int PXY_W   = 50;
  localparam int PZ_W    = 37;
  localparam int CAM_SH  = 28;
  localparam int WLD_SH  = 14;
  localparam int T_W     = 21;
  localparam int T_SH    = 20;

  localparam logic signed [VX_W-1:0]  CAM_RND  = VX_W'(64'sd1 <<< (CAM_SH - 1));
  localparam logic signed [ACC_W-1:0] WLD_RND  = ACC_W'(64'sd1 <<< (WLD_SH - 1));

  // stage 1: z times reciprocal focal lengths
  logic                   b1_valid;
  q_item_t                b1_item;
  logic [ZF_W-1:0]        b1_zfx;
  logic [ZF_W-1:0]        b1_zfy;
  // stage 2: offset times the split products
  logic                   b2_valid;
  logic signed [PP_W-1:0] b2_pxl, b2_pxh, b2_pyl, b2_pyh;
  logic [Z_W-1:0]         b2_z;
  rgb_t                   b2_rgb;
  // stage 3: rounded camera point
  logic                   b3_valid;
  logic signed [CAM_W-1:0] b3_x, b3_y;
  logic [Z_W-1:0]         b3_z;
  rgb_t                   b3_rgb;
  // stage 4: rotation products
  logic                   b4_valid;
  logic signed [PXY_W-1:0] b4_px [3];
  logic signed [PXY_W-1:0] b4_py [3];
  logic signed [PZ_W-1:0]  b4_pz [3];
  rgb_t                   b4_rgb;
  // stage 5: accumulated world coordinates
  logic                   b5_valid;
  logic signed [ACC_W-1:0] b5_acc [3];
  rgb_t                   b5_rgb;

  logic signed [HALF_W:0]  zfx_lo, zfx_hi, zfy_lo, zfy_hi;
  logic signed [VX_W-1:0]  vx, vy, rx, ry;
  logic signed [Z_W:0]     zs;
  logic signed [15:0]      rot [3][3];
  logic signed [T_W-1:0]   tr [3];
  logic [47:0]             rows [3];
  logic signed [ACC_W-1:0] acc [3];
  logic signed [ACC_W-1:0] rnd [3];
  logic signed [OUT_W-1:0] wld [3];

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      b2_valid <= 1'b0;
      b3_valid <= 1'b0;
      b4_valid <= 1'b0;
      b5_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      b1_valid <= head_valid;
      b2_valid <= b1_valid;
      b3_valid <= b2_valid;
      b4_valid <= b3_valid;
      b5_valid <= b4_valid;
      done     <= b5_valid;
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (head_valid) begin
      b1_item <= head_item;
      b1_zfx  <= ZF_W'(head_item.z) * ZF_W'(cfg.inv_focal[23:0]);
      b1_zfy  <= ZF_W'(head_item.z) * ZF_W'(cfg.inv_focal[47:24]);
    end
  end

  // stage 2: split the wide factor into two partial products
  assign zfx_lo = $signed({1'b0, b1_zfx[HALF_W-1:0]});
  assign zfx_hi = $signed({1'b0, b1_zfx[ZF_W-1:HALF_W]});
  assign zfy_lo = $signed({1'b0, b1_zfy[HALF_W-1:0]});
  assign zfy_hi = $signed({1'b0, b1_zfy[ZF_W-1:HALF_W]});

  always_ff @(posedge clk) begin
    if (b1_valid) begin
      b2_pxl <= b1_item.du * zfx_lo;
      b2_pxh <= b1_item.du * zfx_hi;
      b2_pyl <= b1_item.dv * zfy_lo;
      b2_pyh <= b1_item.dv * zfy_hi;
      b2_z   <= b1_item.z;
      b2_rgb <= b1_item.rgb;
    end
  end

  // stage 3: join partials, round half away from zero
  assign vx = (VX_W'(b2_pxh) <<< HALF_W) + VX_W'(b2_pxl);
  assign vy = (VX_W'(b2_pyh) <<< HALF_W) + VX_W'(b2_pyl);
  assign rx = (vx + (vx[VX_W-1] ? CAM_RND - VX_W'(1) : CAM_RND)) >>> CAM_SH;
  assign ry = (vy + (vy[VX_W-1] ? CAM_RND - VX_W'(1) : CAM_RND)) >>> CAM_SH;

  always_ff @(posedge clk) begin
    if (b2_valid) begin
      b3_x   <= rx[CAM_W-1:0];
      b3_y   <= ry[CAM_W-1:0];
      b3_z   <= b2_z;
      b3_rgb <= b2_rgb;
    end
  end

  // rotation terms and translation per lane
  assign rows[0] = cfg.rot_row0;
  assign rows[1] = cfg.rot_row1;
  assign rows[2] = cfg.rot_row2;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rot[i][j] = $signed(rows[i][16*j +: 16]);
      end
      tr[i] = $signed(cfg.translation[T_W*i +: T_W]);
    end
  end

  assign zs = $signed({1'b0, b3_z});

  // stage 4: rotation products
  always_ff @(posedge clk) begin
    if (b3_valid) begin
      for (int i = 0; i < 3; i++) begin
        b4_px[i] <= rot[i][0] * b3_x;
        b4_py[i] <= rot[i][1] * b3_y;
        b4_pz[i] <= rot[i][2] * zs;
      end
      b4_rgb <= b3_rgb;
    end
  end

  // stage 5: sum with translation
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = ACC_W'(b4_px[i]) + ACC_W'(b4_py[i]) + ACC_W'(b4_pz[i])
               + (ACC_W'(tr[i]) <<< T_SH);
    end
  end

  always_ff @(posedge clk) begin
    if (b4_valid) begin
      for (int i = 0; i < 3; i++) begin
        b5_acc[i] <= acc[i];
      end
      b5_rgb <= b4_rgb;
    end
  end

  // round and saturate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i] = (b5_acc[i] + (b5_acc[i][ACC_W-1] ? WLD_RND - ACC_W'(1) : WLD_RND))
               >>> WLD_SH;
      if (rnd[i] > ACC_W'(OUT_MAX)) begin
        wld[i] = OUT_MAX;
      end else if (rnd[i] < ACC_W'(OUT_MIN)) begin
        wld[i] = OUT_MIN;
      end else begin
        wld[i] = rnd[i][OUT_W-1:0];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (b5_valid) begin
      point.world_x   <= wld[0];
      point.world_y   <= wld[1];
      point.world_z   <= wld[2];
      point.blue_out  <= b5_rgb.blue;
      point.green_out <= b5_rgb.green;
      point.red_out   <= b5_rgb.red;
    end
  end

endmodule

/* hw/rtl/depth_pixel_back_projection_core.sv */
// channel   | ports                                   | handshake
// ----------+-----------------------------------------+---------------------------
// pixel in  | start, busy, pixel                      | taken when start & !busy
// point out | done, point                             | one-cycle strobe, no stall
// config    | psel, penable, pwrite, paddr, pwdata,   | apb, write on access phase,
//           | prdata, pready                          | pready tied high
//
// one pixel per clock, sustained
// a point passes the front stages, the queue and the back stages; zero depth or
// depth beyond the far limit gives no point at all
// reset: synchronous, active high; clears all valids, the queue and the registers
// busy rises only when the front queue could not hold every item in flight,
// which does not happen since the back end drains one item every cycle
module depth_pixel_back_projection_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  dpbp_pkg::pixel_t             pixel,
  output logic                         done,
  output dpbp_pkg::point_t             point,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dpbp_pkg::ADDR_W-1:0]  paddr,
  input  logic [dpbp_pkg::DATA_W-1:0]  pwdata,
  output logic [dpbp_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import dpbp_pkg::*;

  cfg_t             cfg;
  logic             push;
  q_item_t          push_item;
  logic             head_valid;
  q_item_t          head_item;
  logic [CNT_W-1:0] q_count;

  // configuration registers
  dpbp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // accept, scale depth and classify
  dpbp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .pixel     (pixel),
    .cfg       (cfg),
    .q_count   (q_count),
    .push      (push),
    .push_item (push_item)
  );

  // queue between front and back
  dpbp_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .head_valid (head_valid),
    .head_item  (head_item),
    .count      (q_count)
  );

  // projection and world transform
  dpbp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .cfg        (cfg),
    .done       (done),
    .point      (point)
  );

endmodule
